FILE: design/url_percent_decoder_unit_assert.svh
// Assertion macros shared by the percent decoder modules.
`ifndef URL_PERCENT_DECODER_UNIT_ASSERT_SVH
`define URL_PERCENT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// Next-cycle implication, checked outside reset.
`define UPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

FILE: design/upd_pkg.sv
// Shared types and constants of the URL percent decoder.
package upd_pkg;

  // Default depth of the queue between front and back end
  localparam int unsigned QDEPTH_DEF = 4;

  // Up to three decoded bytes caused by one input transaction
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;   // 1 to 3 bytes in use
    logic            last;  // input byte closed the string
  } desc_t;

  // Descriptor with a valid flag, used on the queue write and head sides
  typedef struct packed {
    logic  vld;
    desc_t desc;
  } slot_t;

endpackage

FILE: design/upd_in_if.sv
// Encoded byte channel: valid/ready handshake with byte and end flag.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: design/upd_out_if.sv
// Decoded byte channel: valid/ready handshake with byte and framing flags.
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                output ready);
endinterface

FILE: design/upd_front.sv
// Front end: accepts encoded bytes, tracks escape state, builds byte groups.
module upd_front
  import upd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    enc,
  input  logic      q_full,
  output slot_t     q_wr
);

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_PCT    = 2'd1,
    MODE_DIGIT  = 2'd2
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  held, held_next;
  logic [7:0]  c;
  logic        hex;
  logic        norm;
  logic        accept;
  logic [2:0][7:0] bytes;
  logic [1:0]  n;

  // Hex digit value; letters of either case carry bit 6
  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    hex_val = ch[6] ? (ch[3:0] + 4'd9) : ch[3:0];
  endfunction

  assign c      = enc.in_byte;
  assign hex    = ((c >= 8'h30) && (c <= 8'h39)) ||
                  ((c >= 8'h41) && (c <= 8'h46)) ||
                  ((c >= 8'h61) && (c <= 8'h66));
  assign enc.ready = !q_full;
  assign accept = enc.valid && enc.ready;

  // Decode one byte against the current mode, then flush on end of string
  always_comb begin
    mode_next = mode;
    held_next = held;
    bytes     = '0;
    n         = 2'd0;
    norm      = 1'b0;
    unique case (mode)
      MODE_PCT: begin
        if (hex) begin
          held_next = c;
          mode_next = MODE_DIGIT;
        end else begin
          bytes[n] = CH_PCT;
          n        = n + 2'd1;
          norm     = 1'b1;
        end
      end
      MODE_DIGIT: begin
        held_next = 8'd0;
        if (hex) begin
          bytes[n]  = {hex_val(held), hex_val(c)};
          n         = n + 2'd1;
          mode_next = MODE_NORMAL;
        end else begin
          bytes[n] = CH_PCT;
          n        = n + 2'd1;
          bytes[n] = held;
          n        = n + 2'd1;
          norm     = 1'b1;
        end
      end
      default: norm = 1'b1;
    endcase

    // Plain byte handling, also the fallback after a broken escape
    if (norm) begin
      if (c == CH_PLUS) begin
        bytes[n]  = CH_SPACE;
        n         = n + 2'd1;
        mode_next = MODE_NORMAL;
      end else if (c == CH_PCT) begin
        mode_next = MODE_PCT;
      end else begin
        bytes[n]  = c;
        n         = n + 2'd1;
        mode_next = MODE_NORMAL;
      end
    end

    // End of string: emit a pending escape literally and reset
    if (enc.in_last) begin
      if (mode_next == MODE_PCT) begin
        bytes[n] = CH_PCT;
        n        = n + 2'd1;
      end else if (mode_next == MODE_DIGIT) begin
        bytes[n] = CH_PCT;
        n        = n + 2'd1;
        bytes[n] = held_next;
        n        = n + 2'd1;
      end
      mode_next = MODE_NORMAL;
      held_next = 8'd0;
    end
  end

  // Queue write: only transactions that produce bytes
  always_comb begin
    q_wr.vld        = accept && (n != 2'd0);
    q_wr.desc.bytes = bytes;
    q_wr.desc.cnt   = n;
    q_wr.desc.last  = enc.in_last;
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      held <= 8'd0;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

FILE: design/upd_queue.sv
// Descriptor queue between front and back end.
`include "url_percent_decoder_unit_assert.svh"
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  slot_t wr,
  input  logic  pop,
  output slot_t head,
  output logic  full
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  desc_t             store [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;

  assign push = wr.vld;
  assign full = (count == CNT_W'(QDEPTH));

  always_comb begin
    head.vld  = (count != '0);
    head.desc = store[rd_ptr];
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr.desc;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `UPD_ASSERT_NOW(a_no_overflow, push, !full)
  `UPD_ASSERT_NOW(a_no_underflow, pop, count != '0)
  `UPD_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CNT_W'(1))

endmodule

FILE: design/upd_back.sv
// Back end: streams the bytes of the head descriptor one per transaction.
`include "url_percent_decoder_unit_assert.svh"
module upd_back
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  slot_t      head,
  output logic       pop,
  upd_out_if.source  dec
);

  logic [1:0] idx;
  logic       fin;
  logic       fire;

  assign fin  = (idx == (head.desc.cnt - 2'd1));
  assign fire = dec.valid && dec.ready;
  assign pop  = fire && fin;

  // Output byte and framing flags
  assign dec.valid      = head.vld;
  assign dec.out_byte   = head.desc.bytes[idx];
  assign dec.run_last   = fin;
  assign dec.string_end = fin && head.desc.last;

  // Byte position within the head descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= fin ? 2'd0 : idx + 2'd1;
    end
  end

  `UPD_ASSERT_NOW(a_idx_in_range, head.vld, idx < head.desc.cnt)
  `UPD_ASSERT_NOW(a_head_nonempty, head.vld, head.desc.cnt != 2'd0)
  `UPD_ASSERT_NEXT(a_idx_holds, dec.valid && !dec.ready, idx == $past(idx))

endmodule

FILE: design/url_percent_decoder_unit.sv
// URL percent decoder: takes one encoded byte per cycle and returns zero to three
// decoded bytes for it. '+' decodes to a space, '%' with two hex digits to the byte
// they spell; a broken escape is passed through literally, and the byte flagged as
// last flushes any pending escape and closes the string (string_end on its final
// output byte). The front end decodes a transaction in the cycle it is accepted
// and writes its bytes into a QDEPTH-entry queue, where they are registered; the
// back end sends one byte per cycle while the output is ready. Input is taken
// every cycle while the queue has room; throughput is set by the single output
// byte per cycle, so a transaction that yields three bytes occupies the back end
// for three output transfers and input stalls once the queue fills.
module url_percent_decoder_unit
  import upd_pkg::*;
#(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    enc,
  upd_out_if.source dec
);

  slot_t q_wr;
  slot_t head;
  logic  q_full;
  logic  pop;

  upd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .enc    (enc),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  upd_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  upd_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .dec  (dec)
  );

endmodule
